@@ src/pfs_pkg.sv @@
`timescale 1ns / 1ps
// pfs_pkg: shared constants, codes and types for the page frame free stack
// depends on nothing; imported by every module of the block

package pfs_pkg;

    localparam int POOL_DEPTH   = 4096;
    localparam int FRAME_BYTES  = 4096;

    localparam int FRAME_W      = 40;
    localparam int LEN_W        = 52;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int FREE_COUNT_W = 13;

    localparam int ADDR_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
    localparam int FRAME_SHIFT  = $clog2(FRAME_BYTES);
    localparam int REMAIN_W     = LEN_W - FRAME_SHIFT + 1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_REGION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // what the step unit hands back to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]    count_inc;
        logic [CNT_W-1:0]    count_dec;
        logic [FRAME_W-1:0]  cursor_inc;
        logic [REMAIN_W-1:0] remain_dec;
        logic                full;
        logic                empty;
        logic                remain_zero;
    } step_t;

endpackage

@@ src/page_frame_free_stack.sv @@
`timescale 1ns / 1ps
// page_frame_free_stack: top level, lifo pool of free 4 KiB page frames
// depends on pfs_pkg, pfs_store, pfs_step
//
// channel   direction  handshake              word
// -------   ---------  ---------------------  -------------------------------------------
// item      in         start high, busy low   kind, region_base_frame, region_length,
//                                             region_usable, freed_frame
// result    out        done high, one cycle   frame, status, free_count
//
// allocate reads the top entry from the store, then presents it; empty-pool allocate,
// free, kind 3, a non-usable or empty region: result the cycle after start
// a usable region pushes one frame per cycle through the single store write port
// until the region is used up or the pool is full, then presents the result
// reset clears the pointer and the sequencer; stored entries are not cleared
// the receiver cannot stall: every result is shown for exactly one cycle

module page_frame_free_stack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pfs_pkg::KIND_W-1:0]          kind,
    input  logic [pfs_pkg::FRAME_W-1:0]         region_base_frame,
    input  logic [pfs_pkg::LEN_W-1:0]           region_length,
    input  logic                                region_usable,
    input  logic [pfs_pkg::FRAME_W-1:0]         freed_frame,
    output logic                                done,
    output logic [pfs_pkg::FRAME_W-1:0]         frame,
    output logic [pfs_pkg::STATUS_W-1:0]        status,
    output logic [pfs_pkg::FREE_COUNT_W-1:0]    free_count
);
    import pfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_POP  = 3'b100
    } state_t;

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [FRAME_W-1:0]  cursor_reg, cursor_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                done_reg,   done_next;

    // result word, held between strobes
    logic [FRAME_W-1:0]  res_frame_reg,  res_frame_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_count_reg,  res_count_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [FRAME_W-1:0]  wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [FRAME_W-1:0]  rd_data;

    step_t               step;
    logic [REMAIN_W-1:0] region_frames;

    // frames touched by the region: length rounded up to whole frames
    assign region_frames = {1'b0, region_length[LEN_W-1:FRAME_SHIFT]}
                         + REMAIN_W'(|region_length[FRAME_SHIFT-1:0]);

    pfs_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfs_step u_step (
        .count  (count_reg),
        .cursor (cursor_reg),
        .remain (remain_reg),
        .step   (step)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        remain_next     = remain_reg;
        done_next       = 1'b0;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;

        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = cursor_reg;
        rd_en   = 1'b0;
        rd_addr = step.count_dec[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // most items finish at once with frame zero
                    done_next       = 1'b1;
                    res_frame_next  = '0;
                    res_status_next = ST_OK;
                    res_count_next  = count_reg;
                    case (kind)
                        KIND_REGION:
                        begin
                            if (region_usable && (region_frames != '0))
                            begin
                                done_next   = 1'b0;
                                cursor_next = region_base_frame;
                                remain_next = region_frames;
                                state_next  = S_LOAD;
                            end
                        end
                        KIND_ALLOC:
                        begin
                            if (step.empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // fetch the top entry, result follows
                                done_next  = 1'b0;
                                rd_en      = 1'b1;
                                count_next = step.count_dec;
                                state_next = S_POP;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (step.full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data        = freed_frame;
                                count_next     = step.count_inc;
                                res_count_next = step.count_inc;
                            end
                        end
                        default:
                        begin
                            // unused kind: no change, ok result
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (step.remain_zero || step.full)
                begin
                    // region done, or the rest of it is dropped
                    done_next       = 1'b1;
                    res_frame_next  = '0;
                    res_status_next = step.remain_zero ? ST_OK : ST_FULL;
                    res_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    wr_en       = 1'b1;
                    count_next  = step.count_inc;
                    cursor_next = step.cursor_inc;
                    remain_next = step.remain_dec;
                end
            end
            S_POP:
            begin
                done_next       = 1'b1;
                res_frame_next  = rd_data;
                res_status_next = ST_OK;
                res_count_next  = count_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        cursor_reg     <= cursor_next;
        remain_reg     <= remain_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign frame      = res_frame_reg;
    assign status     = res_status_reg;
    assign free_count = FREE_COUNT_W'(res_count_reg);

endmodule

@@ src/pfs_store.sv @@
`timescale 1ns / 1ps
// pfs_store: stack storage of frame numbers, one write and one read port
// depends on pfs_pkg; read data is registered

module pfs_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [pfs_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [pfs_pkg::FRAME_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [pfs_pkg::ADDR_W-1:0]  rd_addr,
    output logic [pfs_pkg::FRAME_W-1:0] rd_data
);
    import pfs_pkg::*;

    logic [FRAME_W-1:0] mem [POOL_DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/pfs_step.sv @@
`timescale 1ns / 1ps
// pfs_step: shared step unit for the stack pointer, frame cursor and region countdown
// depends on pfs_pkg; purely combinational

module pfs_step (
    input  logic [pfs_pkg::CNT_W-1:0]    count,
    input  logic [pfs_pkg::FRAME_W-1:0]  cursor,
    input  logic [pfs_pkg::REMAIN_W-1:0] remain,
    output pfs_pkg::step_t               step
);
    import pfs_pkg::*;

    always_comb
    begin
        step.count_inc   = count + CNT_W'(1);
        step.count_dec   = count - CNT_W'(1);
        // frame numbers wrap modulo 2^40
        step.cursor_inc  = cursor + FRAME_W'(1);
        step.remain_dec  = remain - REMAIN_W'(1);
        step.full        = (count == CNT_W'(POOL_DEPTH));
        step.empty       = (count == '0);
        step.remain_zero = (remain == '0);
    end

endmodule

@@ src/pfs_checker.sv @@
`timescale 1ns / 1ps
// pfs_checker: port-level assertions for the page frame free stack
// depends on pfs_pkg; bound to page_frame_free_stack below

module pfs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [pfs_pkg::FRAME_W-1:0]         frame,
    input  logic [pfs_pkg::STATUS_W-1:0]        status,
    input  logic [pfs_pkg::FREE_COUNT_W-1:0]    free_count
);
    import pfs_pkg::*;

    // an accepted word either finishes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither finished nor in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
        else $error("result carries an unknown status code");

    // an empty result gives frame zero and a free count of zero
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (frame == '0 && free_count == '0))
        else $error("empty result with frame or count set");

    // a dropped push only happens against a full pool
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |->
            (frame == '0 && free_count == FREE_COUNT_W'(POOL_DEPTH)))
        else $error("full result while the pool has room");

endmodule

bind page_frame_free_stack pfs_checker u_pfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .frame      (frame),
    .status     (status),
    .free_count (free_count)
);
